[src/dda_line_rasterizer_defines.svh]
// Assertion macros shared by the line rasterizer modules
`ifndef DDA_LINE_RASTERIZER_DEFINES_SVH
`define DDA_LINE_RASTERIZER_DEFINES_SVH

`ifndef SYNTHESIS
`define DDA_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
`define DDA_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define DDA_ASSERT_IMP(name, ante, cons)
`define DDA_ASSERT_NXT(name, ante, cons)
`endif

`endif

[src/dda_pkg.sv]
// Shared constants and types of the DDA line rasterizer
package dda_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[src/dda_div.sv]
// Shared restoring divider: one quotient bit per cycle of (num << FRAC_BITS) / den
module dda_div
    import dda_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [COORD_BITS:0]    num,
    input  logic [COORD_BITS:0]    den,
    output logic [FRAC_BITS:0]     quot,
    output div_stat_t              stat
);

`include "dda_line_rasterizer_defines.svh"

    localparam int NUM_W = COORD_BITS + 1;
    localparam int DVD_W = NUM_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam int Q_W   = FRAC_BITS + 1;

    logic [DVD_W-1:0] dvd_reg;
    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [NUM_W:0]   shifted;
    logic [NUM_W:0]   diff;
    logic             ge;

    always_comb
    begin
        shifted = {rem_reg, dvd_reg[DVD_W-1]};
        ge      = shifted >= {1'b0, den_reg};
        diff    = shifted - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DVD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != CNT_W'(1));
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {num, {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[NUM_W-1:0] : shifted[NUM_W-1:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], ge};
        end
    end

    assign quot      = dvd_reg[Q_W-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `DDA_ASSERT_IMP(a_busy_has_count, busy_reg, cnt_reg != '0)
    `DDA_ASSERT_IMP(a_done_not_busy, done_reg, !busy_reg)
    `DDA_ASSERT_NXT(a_start_goes_busy, start, busy_reg)

endmodule

[src/dda_line_rasterizer.sv]
// Top level of the DDA line rasterizer: sequencer, accumulators and output register
//
//  channel  | ports                                       | direction
//  ---------+---------------------------------------------+----------
//  item     | item_valid item_ready mode start_x start_y  | in
//           | end_x end_y                                 |
//  point    | point_valid point_ready point_x point_y last| out
//
//  A tick word emits one point while a line runs; points stream back to
//  back while point_ready is high. A load word of a nonzero line runs the
//  shared divider, which yields one quotient bit per cycle, first for x,
//  then for y; item_ready is low during that time. A zero-length load
//  emits its start point, marked last. item_ready is also low while a
//  point waits on a stalled point_ready. Reset leaves the block idle.
module dda_line_rasterizer
    import dda_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic                         mode,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    output logic                         point_valid,
    input  logic                         point_ready,
    output logic signed [COORD_BITS-1:0] point_x,
    output logic signed [COORD_BITS-1:0] point_y,
    output logic                         last
);

`include "dda_line_rasterizer_defines.svh"

    localparam int NUM_W  = COORD_BITS + 1;
    localparam int ACC_W  = COORD_BITS + FRAC_BITS;
    localparam int STEP_W = FRAC_BITS + 2;

    localparam logic [ACC_W-1:0] HALF =
        {{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIV_X = 4'b0010,
        S_DIV_Y = 4'b0100,
        S_RUN   = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic             point_valid_reg, point_valid_next;
    logic [NUM_W-1:0] steps_left_reg, steps_left_next;

    logic [ACC_W-1:0]      acc_x_reg, acc_y_reg;
    logic [STEP_W-1:0]     step_x_reg, step_y_reg;
    logic [NUM_W-1:0]      st_reg, ady_reg;
    logic                  neg_x_reg, neg_y_reg;
    logic [COORD_BITS-1:0] point_x_reg, point_y_reg;
    logic                  last_reg;

    logic [NUM_W-1:0]      dx, dy, adx, ady, st_in;
    logic                  accept, load, tick, zero_len, out_free;
    logic [ACC_W-1:0]      sum_x, sum_y;
    logic [NUM_W-1:0]      div_num, div_den;
    logic                  div_start;
    logic [FRAC_BITS:0]    quot;
    div_stat_t             div_stat;
    logic [STEP_W-1:0]     q_ext, step_val;
    logic                  step_neg;

    always_comb
    begin
        dx       = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
        dy       = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
        adx      = dx[NUM_W-1] ? -dx : dx;
        ady      = dy[NUM_W-1] ? -dy : dy;
        st_in    = (adx > ady) ? adx : ady;
        zero_len = (st_in == '0);

        out_free   = !point_valid_reg || point_ready;
        item_ready = ((state_reg == S_IDLE) || (state_reg == S_RUN)) && out_free;
        accept     = item_valid && item_ready;
        load       = accept && (mode == MODE_LOAD);
        tick       = accept && (mode == MODE_TICK) && (state_reg == S_RUN);

        sum_x = acc_x_reg + HALF;
        sum_y = acc_y_reg + HALF;

        div_start = (load && !zero_len) || ((state_reg == S_DIV_X) && div_stat.done);
        div_num   = (state_reg == S_DIV_X) ? ady_reg : adx;
        div_den   = (state_reg == S_DIV_X) ? st_reg : st_in;

        q_ext    = {1'b0, quot};
        step_neg = (state_reg == S_DIV_X) ? neg_x_reg : neg_y_reg;
        step_val = step_neg ? -q_ext : q_ext;
    end

    dda_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (quot),
        .stat  (div_stat)
    );

    always_comb
    begin
        state_next       = state_reg;
        steps_left_next  = steps_left_reg;
        point_valid_next = point_valid_reg && !point_ready;
        unique case (state_reg) inside
            S_IDLE, S_RUN:
            begin
                if (load)
                begin
                    if (zero_len)
                    begin
                        state_next       = S_IDLE;
                        steps_left_next  = '0;
                        point_valid_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_DIV_X;
                    end
                end
                else if (tick)
                begin
                    point_valid_next = 1'b1;
                    steps_left_next  = steps_left_reg - 1'b1;
                    if (steps_left_reg == NUM_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DIV_X:
            begin
                if (div_stat.done)
                begin
                    state_next = S_DIV_Y;
                end
            end
            S_DIV_Y:
            begin
                if (div_stat.done)
                begin
                    state_next      = S_RUN;
                    steps_left_next = st_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            point_valid_reg <= 1'b0;
            steps_left_reg  <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            point_valid_reg <= point_valid_next;
            steps_left_reg  <= steps_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            acc_x_reg <= {start_x, {FRAC_BITS{1'b0}}};
            acc_y_reg <= {start_y, {FRAC_BITS{1'b0}}};
            st_reg    <= st_in;
            ady_reg   <= ady;
            neg_x_reg <= dx[NUM_W-1];
            neg_y_reg <= dy[NUM_W-1];
            if (zero_len)
            begin
                point_x_reg <= start_x;
                point_y_reg <= start_y;
                last_reg    <= 1'b1;
            end
        end
        else if (tick)
        begin
            point_x_reg <= sum_x[ACC_W-1:FRAC_BITS];
            point_y_reg <= sum_y[ACC_W-1:FRAC_BITS];
            last_reg    <= (steps_left_reg == NUM_W'(1));
            acc_x_reg   <= acc_x_reg + {{(ACC_W-STEP_W){step_x_reg[STEP_W-1]}}, step_x_reg};
            acc_y_reg   <= acc_y_reg + {{(ACC_W-STEP_W){step_y_reg[STEP_W-1]}}, step_y_reg};
        end

        if ((state_reg == S_DIV_X) && div_stat.done)
        begin
            step_x_reg <= step_val;
        end
        if ((state_reg == S_DIV_Y) && div_stat.done)
        begin
            step_y_reg <= step_val;
        end
    end

    assign point_valid = point_valid_reg;
    assign point_x     = point_x_reg;
    assign point_y     = point_y_reg;
    assign last        = last_reg;

    `DDA_ASSERT_IMP(a_no_accept_dividing, (state_reg == S_DIV_X) || (state_reg == S_DIV_Y), !item_ready)
    `DDA_ASSERT_IMP(a_run_has_steps, state_reg == S_RUN, steps_left_reg != '0)
    `DDA_ASSERT_NXT(a_div_y_done_runs, (state_reg == S_DIV_Y) && div_stat.done, state_reg == S_RUN)
    `DDA_ASSERT_NXT(a_tick_emits, tick, point_valid_reg)

endmodule
